### rtl/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types, codes and constants of the timed state sequencer.
// ----------------------------------------------------------------------------
package tdss_pkg;

	localparam int MAX_STATES = 16;
	localparam int STATE_W    = 4;
	localparam int CNT_W      = 5;
	localparam int TIME_W     = 32;
	localparam int DELAY_W    = 16;
	localparam int DELAY_US_W = 26;
	localparam int US_PER_MS  = 1000;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	typedef enum logic [1:0] {
		OP_EXEC  = 2'd0,
		OP_BEGIN = 2'd1,
		OP_FORCE = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		TM_NONE       = 3'd0,
		TM_TIMER      = 3'd1,
		TM_TIMER_COND = 3'd2,
		TM_FALSE_TMO  = 3'd3,
		TM_TRUE_TMO   = 3'd4
	} timer_mode_t;

	localparam logic REG_STATE_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] STATE_COUNT_RST = CNT_W'(MAX_STATES);

	typedef struct packed {
		logic [STATE_W-1:0]    next_if_false;
		logic [STATE_W-1:0]    next_if_true;
		logic [2:0]            timer_mode;
		logic [DELAY_US_W-1:0] delay_us;
		logic                  has_condition;
		logic                  has_process;
		logic                  has_handler;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [STATE_W-1:0] current_state;
		logic [STATE_W-1:0] left_state;
		logic               exit_event;
		logic               moved;
		logic               is_exec;
		logic               process_now;
		logic               timed_out;
		logic               rejected;
	} step_t;

	function automatic logic [DELAY_US_W-1:0] ms_to_us(input logic [DELAY_W-1:0] ms);
		return DELAY_US_W'(ms) * DELAY_US_W'(US_PER_MS);
	endfunction

endpackage

### rtl/tdss_ram.sv
// ----------------------------------------------------------------------------
// tdss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/tdss_ctrl.sv
// ----------------------------------------------------------------------------
// tdss_ctrl
// Decision stage: holds the current state, entry time, timeout latch and a
// copy of the current table entry; decides each transaction and drives the
// table memory.
// ----------------------------------------------------------------------------
module tdss_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [1:0]                     operation,
	input  logic [tdss_pkg::STATE_W-1:0]   state_index,
	input  logic [tdss_pkg::TIME_W-1:0]    now_us,
	input  logic                           condition,
	input  logic [tdss_pkg::STATE_W-1:0]   next_if_false,
	input  logic [tdss_pkg::STATE_W-1:0]   next_if_true,
	input  logic [2:0]                     timer_mode,
	input  logic [tdss_pkg::DELAY_W-1:0]   delay_ms,
	input  logic                           has_condition,
	input  logic                           has_process,
	input  logic                           has_handler,
	input  logic [tdss_pkg::CNT_W-1:0]     state_count,
	input  tdss_pkg::entry_t               rdata,
	output logic                           ram_we,
	output logic [tdss_pkg::STATE_W-1:0]   ram_waddr,
	output tdss_pkg::entry_t               ram_wdata,
	output logic                           ram_re,
	output logic [tdss_pkg::STATE_W-1:0]   ram_raddr,
	output tdss_pkg::step_t                step
);
	import tdss_pkg::*;

	logic [STATE_W-1:0] state_q;
	logic [TIME_W-1:0]  time_q;
	logic               latch_q;
	logic               fwd_q;
	entry_t             cur_q;

	entry_t             cur;
	entry_t             wentry;
	op_t                op;
	logic [CNT_W-1:0]   cnt;
	logic               rej;
	logic [TIME_W-1:0]  elapsed;
	logic               reached;
	logic               consult;
	logic               tmr;
	logic               go;
	logic [STATE_W-1:0] tgt;
	logic [STATE_W-1:0] nxt_state;
	logic [TIME_W-1:0]  nxt_time;
	logic               nxt_latch;
	logic               moved;
	logic               exit_ev;
	logic [STATE_W-1:0] left;
	logic               wr_hit;

	assign op  = op_t'(operation);
	assign cur = fwd_q ? rdata : cur_q;

	assign wentry.next_if_false = next_if_false;
	assign wentry.next_if_true  = next_if_true;
	assign wentry.timer_mode    = timer_mode;
	assign wentry.delay_us      = ms_to_us(delay_ms);
	assign wentry.has_condition = has_condition;
	assign wentry.has_process   = has_process;
	assign wentry.has_handler   = has_handler;

	always_comb begin
		if (state_count == '0) begin
			cnt = CNT_W'(1);
		end else if (state_count > CNT_W'(MAX_STATES)) begin
			cnt = CNT_W'(MAX_STATES);
		end else begin
			cnt = state_count;
		end
	end

	assign rej     = {1'b0, state_index} >= cnt;
	assign elapsed = now_us - time_q;
	assign reached = (cur.delay_us != '0) && (latch_q || (elapsed >= TIME_W'(cur.delay_us)));

	always_comb begin
		consult = 1'b0;
		go      = 1'b0;
		tgt     = cur.next_if_true;
		case (cur.timer_mode)
			TM_NONE: begin
				go  = cur.has_condition;
				tgt = condition ? cur.next_if_true : cur.next_if_false;
			end
			TM_TIMER: begin
				consult = 1'b1;
				go      = reached;
			end
			TM_TIMER_COND: begin
				consult = 1'b1;
				go      = reached && cur.has_condition;
				tgt     = condition ? cur.next_if_true : cur.next_if_false;
			end
			TM_FALSE_TMO: begin
				consult = 1'b1;
				go      = cur.has_condition && (condition || reached);
				tgt     = condition ? cur.next_if_true : cur.next_if_false;
			end
			TM_TRUE_TMO: begin
				consult = 1'b1;
				go      = cur.has_condition && (!condition || reached);
				tgt     = condition ? cur.next_if_true : cur.next_if_false;
			end
			default: begin
				consult = 1'b0;
			end
		endcase
	end

	assign tmr = consult && reached;

	always_comb begin
		nxt_state = state_q;
		nxt_time  = time_q;
		nxt_latch = latch_q;
		moved     = 1'b0;
		exit_ev   = 1'b0;
		ram_raddr = state_index;
		case (op)
			OP_BEGIN: begin
				if (!rej) begin
					moved = 1'b1;
				end
			end
			OP_FORCE: begin
				if (!rej && state_index != state_q) begin
					moved   = 1'b1;
					exit_ev = cur.has_handler;
				end
			end
			OP_EXEC: begin
				nxt_latch = latch_q | tmr;
				ram_raddr = tgt;
				if (go && tgt != state_q) begin
					moved   = 1'b1;
					exit_ev = cur.has_handler;
				end
			end
			default: begin
				moved = 1'b0;
			end
		endcase
		if (moved) begin
			nxt_state = ram_raddr;
			nxt_time  = now_us;
			nxt_latch = 1'b0;
		end
	end

	assign left   = exit_ev ? state_q : '0;
	assign wr_hit = (op == OP_WRITE) && (state_index == state_q);

	assign ram_we    = accept && (op == OP_WRITE);
	assign ram_waddr = state_index;
	assign ram_wdata = wentry;
	assign ram_re    = accept && moved;

	assign step.current_state = nxt_state;
	assign step.left_state    = left;
	assign step.exit_event    = exit_ev;
	assign step.moved         = moved;
	assign step.is_exec       = (op == OP_EXEC);
	assign step.process_now   = cur.has_process;
	assign step.timed_out     = nxt_latch;
	assign step.rejected      = rej && (op == OP_BEGIN || op == OP_FORCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			time_q  <= '0;
			latch_q <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			fwd_q <= accept && moved;
			if (accept) begin
				state_q <= nxt_state;
				time_q  <= nxt_time;
				latch_q <= nxt_latch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_hit) begin
			cur_q <= wentry;
		end else begin
			cur_q <= cur;
		end
	end

endmodule

### rtl/tdss_out.sv
// ----------------------------------------------------------------------------
// tdss_out
// Completion stage and output register: merges the handler and process flags
// read from the table into the result and holds it for the response channel.
// ----------------------------------------------------------------------------
module tdss_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  tdss_pkg::step_t              step,
	input  tdss_pkg::entry_t             rdata,
	output logic                         req_ready,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [tdss_pkg::STATE_W-1:0] current_state,
	output logic [tdss_pkg::STATE_W-1:0] left_state,
	output logic                         exit_event,
	output logic                         entry_event,
	output logic                         process_event,
	output logic                         timed_out,
	output logic                         rejected
);
	import tdss_pkg::*;

	logic  valid_s1;
	step_t step_s1;
	logic  adv;

	assign adv       = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
		if (adv) begin
			current_state <= step_s1.current_state;
			left_state    <= step_s1.left_state;
			exit_event    <= step_s1.exit_event;
			entry_event   <= step_s1.moved && rdata.has_handler;
			process_event <= step_s1.is_exec &&
				(step_s1.moved ? rdata.has_process : step_s1.process_now);
			timed_out     <= step_s1.timed_out;
			rejected      <= step_s1.rejected;
		end
	end

endmodule

### rtl/table_driven_timed_state_sequencer.sv
// ----------------------------------------------------------------------------
// table_driven_timed_state_sequencer
// Programmable state sequencer driven by a table of entries held in RAM.
//
//   channel  | handshake              | content
//   ---------+------------------------+---------------------------------------
//   request  | req_valid / req_ready  | operation, index, time, condition, entry
//   response | rsp_valid / rsp_ready  | state, exit/entry/process events, flags
//   config   | APB psel/penable       | state_count at byte address 0
//
// One transaction per cycle while the response is not stalled; an accepted
// transaction passes the completion stage and then the output register.
// A state change reads the new state's entry from the table RAM; the read data
// is forwarded to the decision of the next transaction in the following cycle.
// Reset clears state, entry time, timeout latch and pipeline valids; the table
// is not cleared and needs no sweep.
// A stalled response holds the output register and one more transaction in the
// completion stage, after which req_ready drops.
// ----------------------------------------------------------------------------
module table_driven_timed_state_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tdss_pkg::ADDR_W-1:0]   paddr,
	input  logic [tdss_pkg::DATA_W-1:0]   pwdata,
	output logic [tdss_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    operation,
	input  logic [tdss_pkg::STATE_W-1:0]  state_index,
	input  logic [tdss_pkg::TIME_W-1:0]   now_us,
	input  logic                          condition,
	input  logic [tdss_pkg::STATE_W-1:0]  next_if_false,
	input  logic [tdss_pkg::STATE_W-1:0]  next_if_true,
	input  logic [2:0]                    timer_mode,
	input  logic [tdss_pkg::DELAY_W-1:0]  delay_ms,
	input  logic                          has_condition,
	input  logic                          has_process,
	input  logic                          has_handler,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [tdss_pkg::STATE_W-1:0]  current_state,
	output logic [tdss_pkg::STATE_W-1:0]  left_state,
	output logic                          exit_event,
	output logic                          entry_event,
	output logic                          process_event,
	output logic                          timed_out,
	output logic                          rejected
);
	import tdss_pkg::*;

	logic [CNT_W-1:0]   state_count_q;
	logic               accept;
	logic               ram_we;
	logic [STATE_W-1:0] ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [STATE_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rdata;
	step_t              step;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STATE_COUNT) ? DATA_W'(state_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= STATE_COUNT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STATE_COUNT) begin
			state_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign accept = req_valid && req_ready;
	assign rdata  = entry_t'(ram_rdata);

	tdss_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_STATES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENTRY_W'(ram_wdata)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tdss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.state_index  (state_index),
		.now_us       (now_us),
		.condition    (condition),
		.next_if_false(next_if_false),
		.next_if_true (next_if_true),
		.timer_mode   (timer_mode),
		.delay_ms     (delay_ms),
		.has_condition(has_condition),
		.has_process  (has_process),
		.has_handler  (has_handler),
		.state_count  (state_count_q),
		.rdata        (rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.step         (step)
	);

	tdss_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.step         (step),
		.rdata        (rdata),
		.req_ready    (req_ready),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.current_state(current_state),
		.left_state   (left_state),
		.exit_event   (exit_event),
		.entry_event  (entry_event),
		.process_event(process_event),
		.timed_out    (timed_out),
		.rejected     (rejected)
	);

endmodule
